// ===== src/bpfa_pkg.sv =====
package bpfa_pkg;

	localparam int MAX_FRAMES    = 32768;
	localparam int MAP_WORD_BITS = 64;
	localparam int MAP_WORDS     = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int WORD_IDX_W    = $clog2(MAP_WORDS);
	localparam int BIT_POS_W     = $clog2(MAP_WORD_BITS);
	localparam int FRAME_IDX_W   = WORD_IDX_W + BIT_POS_W;
	localparam int LIMIT_W       = FRAME_IDX_W + 1;
	localparam int FRAME_SHIFT   = 12;

	localparam int ADDR_W      = 64;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 1;
	localparam int FCOUNT_W    = 16;
	localparam int CMD_W       = 2;
	localparam int STS_W       = 2;
	localparam int S_TDATA_W   = 24;
	localparam int M_TDATA_W   = 72;

	localparam int S_IDX_LSB   = CMD_W;
	localparam int S_VAL_BIT   = CMD_W + FRAME_IDX_W;
	localparam int M_BIT_POS   = ADDR_W;
	localparam int M_STS_LSB   = ADDR_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'd1;

	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_NONE  = 2'd1;
	localparam logic [STS_W-1:0] STS_RANGE = 2'd2;

	typedef enum logic [CMD_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_ALLOC = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_CLEAR,
		ST_ALLOC_CHK,
		ST_ACC_CHK,
		ST_RESP
	} state_t;

	typedef enum logic [2:0] {
		RES_OK,
		RES_NONE,
		RES_RANGE,
		RES_ALLOC,
		RES_READ
	} res_kind_t;

	typedef struct packed {
		logic      load_item;
		logic      sweep_wr;
		logic      scan_rd;
		logic      alloc_wr;
		logic      acc_rd;
		logic      acc_wr;
		logic      res_load;
		res_kind_t res_kind;
		logic      out_load;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic in_range;
		logic limit_zero;
		logic sweep_last;
		logic has_free;
		logic chk_last;
		logic out_free;
	} dp_stat_t;

	function automatic logic [BIT_POS_W-1:0] first_set(input logic [MAP_WORD_BITS-1:0] v);
		logic [BIT_POS_W-1:0] pos;
		pos = '0;
		for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				pos = BIT_POS_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

// ===== src/bpfa_ram.sv =====
module bpfa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/bpfa_dp.sv =====
module bpfa_dp import bpfa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat
);

	logic [ADDR_W-1:0]      pool_base_q;
	logic [FCOUNT_W-1:0]    frame_count_q;
	op_t                    op_q;
	logic [FRAME_IDX_W-1:0] idx_q;
	logic                   val_q;
	logic [WORD_IDX_W-1:0]  addr_q;
	logic [WORD_IDX_W-1:0]  chk_addr_s1;
	logic [FRAME_IDX_W-1:0] res_idx_q;
	logic                   res_found_q;
	logic                   res_bit_q;
	logic [STS_W-1:0]       res_sts_q;
	logic                   m_tvalid_q;
	logic [M_TDATA_W-1:0]   m_data_q;

	logic [LIMIT_W-1:0]       limit;
	logic [LIMIT_W-1:0]       lim_m1;
	logic [WORD_IDX_W-1:0]    last_word;
	logic [BIT_POS_W-1:0]     last_bit;
	logic [WORD_IDX_W-1:0]    idx_word;
	logic [BIT_POS_W-1:0]     idx_bit;
	logic [MAP_WORD_BITS-1:0] bit_mask;
	logic [MAP_WORD_BITS-1:0] valid_mask;
	logic [MAP_WORD_BITS-1:0] free_vec;
	logic [BIT_POS_W-1:0]     free_pos;
	logic [ADDR_W-1:0]        frame_addr;

	logic                     ram_we;
	logic [WORD_IDX_W-1:0]    ram_waddr;
	logic [MAP_WORD_BITS-1:0] ram_wdata;
	logic                     ram_re;
	logic [WORD_IDX_W-1:0]    ram_raddr;
	logic [MAP_WORD_BITS-1:0] ram_rdata;

	always_comb begin
		limit = (frame_count_q > FCOUNT_W'(MAX_FRAMES)) ? LIMIT_W'(MAX_FRAMES)
			: LIMIT_W'(frame_count_q);
		lim_m1    = limit - LIMIT_W'(1);
		last_word = lim_m1[FRAME_IDX_W-1:BIT_POS_W];
		last_bit  = lim_m1[BIT_POS_W-1:0];
		idx_word  = idx_q[FRAME_IDX_W-1:BIT_POS_W];
		idx_bit   = idx_q[BIT_POS_W-1:0];
		bit_mask  = MAP_WORD_BITS'(1) << idx_bit;
		valid_mask = (chk_addr_s1 == last_word)
			? ({MAP_WORD_BITS{1'b1}} >> (BIT_POS_W'(MAP_WORD_BITS - 1) - last_bit))
			: {MAP_WORD_BITS{1'b1}};
		free_vec = ~ram_rdata & valid_mask;
		free_pos = first_set(free_vec);
		frame_addr = res_found_q
			? pool_base_q + ADDR_W'({res_idx_q, FRAME_SHIFT'(0)}) : '0;
	end

	always_comb begin
		ram_we    = cmd.sweep_wr | cmd.alloc_wr | cmd.acc_wr;
		ram_waddr = idx_word;
		ram_wdata = (ram_rdata & ~bit_mask) | (val_q ? bit_mask : '0);
		if (cmd.sweep_wr) begin
			ram_waddr = addr_q;
			ram_wdata = '0;
		end else if (cmd.alloc_wr) begin
			ram_waddr = chk_addr_s1;
			ram_wdata = ram_rdata | (MAP_WORD_BITS'(1) << free_pos);
		end
		ram_re    = cmd.scan_rd | cmd.acc_rd;
		ram_raddr = cmd.scan_rd ? addr_q : idx_word;
	end

	bpfa_ram #(
		.WIDTH(MAP_WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= '0;
			frame_count_q <= '0;
			addr_q        <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_POOL_BASE) begin
					pool_base_q <= cfg_data;
				end else if (cfg_index == REG_FRAME_COUNT) begin
					frame_count_q <= cfg_data[FCOUNT_W-1:0];
				end
			end
			if (cmd.load_item) begin
				addr_q <= '0;
			end else if (cmd.sweep_wr || cmd.scan_rd) begin
				addr_q <= addr_q + WORD_IDX_W'(1);
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q  <= op_t'(s_tdata[CMD_W-1:0]);
			idx_q <= s_tdata[S_IDX_LSB +: FRAME_IDX_W];
			val_q <= s_tdata[S_VAL_BIT];
		end
		if (cmd.scan_rd) begin
			chk_addr_s1 <= addr_q;
		end
		if (cmd.res_load) begin
			case (cmd.res_kind)
				RES_NONE: begin
					res_found_q <= 1'b0;
					res_bit_q   <= 1'b0;
					res_sts_q   <= STS_NONE;
				end
				RES_RANGE: begin
					res_found_q <= 1'b0;
					res_bit_q   <= 1'b0;
					res_sts_q   <= STS_RANGE;
				end
				RES_ALLOC: begin
					res_found_q <= 1'b1;
					res_bit_q   <= 1'b0;
					res_sts_q   <= STS_OK;
					res_idx_q   <= {chk_addr_s1, free_pos};
				end
				RES_READ: begin
					res_found_q <= 1'b0;
					res_bit_q   <= ram_rdata[idx_bit];
					res_sts_q   <= STS_OK;
				end
				default: begin
					res_found_q <= 1'b0;
					res_bit_q   <= 1'b0;
					res_sts_q   <= STS_OK;
				end
			endcase
		end
		if (cmd.out_load) begin
			m_data_q <= {(M_TDATA_W - ADDR_W - 1 - STS_W)'(0), res_sts_q, res_bit_q, frame_addr};
		end
	end

	always_comb begin
		stat.op         = op_q;
		stat.in_range   = LIMIT_W'(idx_q) < limit;
		stat.limit_zero = (limit == '0);
		stat.sweep_last = (addr_q == WORD_IDX_W'(MAP_WORDS - 1));
		stat.has_free   = |free_vec;
		stat.chk_last   = (chk_addr_s1 == last_word);
		stat.out_free   = !m_tvalid_q || m_tready;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

endmodule

// ===== src/bpfa_ctrl.sv =====
module bpfa_ctrl import bpfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep_wr = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (stat.op)
					OP_CLEAR: state_d = ST_CLEAR;
					OP_ALLOC: begin
						if (stat.limit_zero) begin
							cmd.res_load = 1'b1;
							cmd.res_kind = RES_NONE;
							state_d      = ST_RESP;
						end else begin
							cmd.scan_rd = 1'b1;
							state_d     = ST_ALLOC_CHK;
						end
					end
					default: begin
						if (!stat.in_range) begin
							cmd.res_load = 1'b1;
							cmd.res_kind = RES_RANGE;
							state_d      = ST_RESP;
						end else begin
							cmd.acc_rd = 1'b1;
							state_d    = ST_ACC_CHK;
						end
					end
				endcase
			end
			ST_CLEAR: begin
				cmd.sweep_wr = 1'b1;
				if (stat.sweep_last) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_OK;
					state_d      = ST_RESP;
				end
			end
			ST_ALLOC_CHK: begin
				if (stat.has_free) begin
					cmd.alloc_wr = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_ALLOC;
					state_d      = ST_RESP;
				end else if (stat.chk_last) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_NONE;
					state_d      = ST_RESP;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			ST_ACC_CHK: begin
				cmd.res_load = 1'b1;
				if (stat.op == OP_WRITE) begin
					cmd.acc_wr   = 1'b1;
					cmd.res_kind = RES_OK;
				end else begin
					cmd.res_kind = RES_READ;
				end
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== src/bitmap_page_frame_allocator.sv =====
// Bitmap first-fit page frame allocator, one map bit per 4 KiB frame (1 used, 0 free).
// Input stream s_*: one command per transfer (clear, allocate, write bit, read bit).
// Output stream m_*: exactly one result transfer per command, in command order.
// Configuration: cfg_we/cfg_index/cfg_data write pool_base (index 0) and frame_count
// (index 1); write them only while no command is in flight.
// The map lives in a 512 x 64 RAM with registered read. Steps per command:
//   write or read bit: decode, map read and update, output register; out-of-range index: decode, output register.
//   allocate: decode, then N map words scanned, one word per cycle through a
//   priority encoder, at most ceil(min(frame_count, 32768) / 64) = 512.
//   clear: all 512 RAM words zeroed, one word per cycle.
// One command is in work at a time; s_tready rises again once its result has moved
// into the output register, so the next command is taken while that result waits.
// Reset: a pass over all 512 map words zeroes the map; s_tready stays low until it is done.
// When m_tready is low the result holds in the output register and the next
// command stalls only at its own result step.
module bitmap_page_frame_allocator import bpfa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // cmd[1:0], bit_index[16:2], bit_value_in[17], zeros
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata    // frame_address[63:0], bit_read[64], status[66:65], zeros
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bpfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bpfa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a command is in work");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[M_STS_LSB +: STS_W] != STS_OK)
			|-> (m_tdata[ADDR_W-1:0] == '0) && !m_tdata[M_BIT_POS])
		else $error("failed command carries address or bit");

	a_sts_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[M_STS_LSB +: STS_W] == STS_OK)
			|| (m_tdata[M_STS_LSB +: STS_W] == STS_NONE)
			|| (m_tdata[M_STS_LSB +: STS_W] == STS_RANGE))
		else $error("bad status code");

	a_alloc_writes_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_wr |-> cmd.res_load && !cmd.sweep_wr && !cmd.acc_wr)
		else $error("allocate map update collides");

endmodule

// ===== dv/tb.sv =====
module tb;
	import bpfa_pkg::*;

	typedef struct packed {
		op_t                    op;
		logic [FRAME_IDX_W-1:0] idx;
		logic                   val;
	} frame_cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              rd;
		logic [STS_W-1:0]  sts;
	} frame_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // cmd, bit_index, bit_value_in, zeros
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;   // frame_address, bit_read, status, zeros

	frame_cmd_t    cmd_q[$];
	frame_result_t pending_results[$];
	frame_cmd_t    cur_cmd;
	frame_result_t got;
	frame_result_t want;

	logic [MAP_WORD_BITS-1:0] shadow_map [MAP_WORDS];
	logic [ADDR_W-1:0]        pool_shadow;
	logic [FCOUNT_W-1:0]      fcount_shadow;

	int unsigned gap_cnt;
	int unsigned stall_cnt;
	int unsigned stall_draw;
	int unsigned errors = 0;
	bit          gaps_on = 1'b1;

	bitmap_page_frame_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic frame_result_t apply_command(frame_cmd_t c);
		frame_result_t r;
		int unsigned   lim;
		int unsigned   i;
		r = '0;
		lim = (fcount_shadow > MAX_FRAMES) ? MAX_FRAMES : fcount_shadow;
		case (c.op)
			OP_CLEAR: begin
				foreach (shadow_map[w])
					shadow_map[w] = '0;
			end
			OP_ALLOC: begin
				i = 0;
				while (i < lim && shadow_map[i / MAP_WORD_BITS][i % MAP_WORD_BITS])
					i++;
				if (i < lim) begin
					shadow_map[i / MAP_WORD_BITS][i % MAP_WORD_BITS] = 1'b1;
					r.addr = pool_shadow + (64'(i) << FRAME_SHIFT);
				end else begin
					r.sts = STS_NONE;
				end
			end
			OP_WRITE: begin
				if (c.idx >= lim)
					r.sts = STS_RANGE;
				else
					shadow_map[c.idx / MAP_WORD_BITS][c.idx % MAP_WORD_BITS] = c.val;
			end
			default: begin
				if (c.idx >= lim)
					r.sts = STS_RANGE;
				else
					r.rd = shadow_map[c.idx / MAP_WORD_BITS][c.idx % MAP_WORD_BITS];
			end
		endcase
		return r;
	endfunction

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			gap_cnt  <= 0;
		end else begin
			if (s_tvalid && s_tready)
				pending_results.push_back(apply_command(cur_cmd));
			if (!s_tvalid || s_tready) begin
				if (gap_cnt != 0) begin
					gap_cnt  <= gap_cnt - 1;
					s_tvalid <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					cur_cmd  = cmd_q.pop_front();
					s_tdata  <= S_TDATA_W'({cur_cmd.val, cur_cmd.idx, cur_cmd.op});
					s_tvalid <= 1'b1;
					gap_cnt  <= gaps_on ? $urandom_range(0, 19) : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			stall_cnt <= 0;
		end else if (m_tvalid && m_tready) begin
			got = '{addr: m_tdata[ADDR_W-1:0], rd: m_tdata[M_BIT_POS],
				sts: m_tdata[M_STS_LSB +: STS_W]};
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected transfer, actual addr %h bit %b status %0d",
					$time, got.addr, got.rd, got.sts);
			end else begin
				want = pending_results.pop_front();
				if (got.addr !== want.addr) begin
					errors++;
					$display("%0t: frame_address expected %h actual %h",
						$time, want.addr, got.addr);
				end
				if (got.rd !== want.rd) begin
					errors++;
					$display("%0t: bit_read expected %b actual %b", $time, want.rd, got.rd);
				end
				if (got.sts !== want.sts) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, want.sts, got.sts);
				end
			end
			stall_draw = gaps_on ? $urandom_range(0, 19) : 0;
			stall_cnt <= stall_draw;
			m_tready  <= (stall_draw == 0);
		end else if (stall_cnt != 0) begin
			stall_cnt <= stall_cnt - 1;
			m_tready  <= (stall_cnt == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic push_cmd(op_t op, int unsigned idx, logic val);
		frame_cmd_t c;
		c.op  = op;
		c.idx = FRAME_IDX_W'(idx);
		c.val = val;
		cmd_q.push_back(c);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_POOL_BASE)
			pool_shadow = data;
		else
			fcount_shadow = data[FCOUNT_W-1:0];
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (cmd_q.size() != 0 || pending_results.size() != 0 || s_tvalid);
	endtask

	initial begin
		int unsigned       p;
		int unsigned       k;
		int unsigned       lim;
		int unsigned       pick;
		int unsigned       idx;
		logic [ADDR_W-1:0] base;
		logic [15:0]       fc;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		pool_shadow   = '0;
		fcount_shadow = '0;
		foreach (shadow_map[w])
			shadow_map[w] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// registers still at reset: nothing in range
		push_cmd(OP_ALLOC, 0, 1'b0);
		push_cmd(OP_READ, 0, 1'b0);
		push_cmd(OP_WRITE, 32767, 1'b1);
		drain();

		write_reg(REG_POOL_BASE, 64'h0000_0000_1000_0000);
		write_reg(REG_FRAME_COUNT, 64'd5);
		repeat (6) push_cmd(OP_ALLOC, 0, 1'b0);
		push_cmd(OP_READ, 4, 1'b0);
		push_cmd(OP_READ, 5, 1'b0);
		push_cmd(OP_WRITE, 2, 1'b0);
		push_cmd(OP_ALLOC, 0, 1'b0);
		push_cmd(OP_WRITE, 4, 1'b0);
		push_cmd(OP_READ, 4, 1'b0);
		push_cmd(OP_READ, 0, 1'b0);
		push_cmd(OP_CLEAR, 32767, 1'b1);
		push_cmd(OP_READ, 0, 1'b0);
		push_cmd(OP_ALLOC, 0, 1'b0);
		drain();

		// top of the address space, count saturated
		write_reg(REG_POOL_BASE, 64'hFFFF_FFFF_FFFF_F000);
		write_reg(REG_FRAME_COUNT, 64'hFFFF);
		push_cmd(OP_ALLOC, 0, 1'b0);
		push_cmd(OP_ALLOC, 0, 1'b0);
		push_cmd(OP_WRITE, 32767, 1'b1);
		push_cmd(OP_READ, 32767, 1'b0);
		push_cmd(OP_WRITE, 32767, 1'b0);
		push_cmd(OP_READ, 32767, 1'b0);
		drain();

		for (p = 0; p < 10; p++) begin
			case (p)
				0: fc = 16'd1;
				1: fc = 16'd40;
				2: fc = 16'd64;
				3: fc = 16'd65;
				4: fc = 16'd200;
				5: fc = 16'd32768;
				6: fc = 16'hFFFF;
				7: fc = 16'd0;
				8: fc = 16'($urandom_range(1, 300));
				default: fc = 16'($urandom_range(0, 65535));
			endcase
			case (p % 3)
				0: base = {$urandom, $urandom};
				1: base = {$urandom, $urandom} & ~64'hFFF;
				default: base = 64'hFFFF_FFFF_FFFF_F000;
			endcase
			if (p == 7)
				base = '0;
			gaps_on = (p % 3 != 2);
			write_reg(REG_POOL_BASE, base);
			write_reg(REG_FRAME_COUNT, 64'(fc));
			lim = (fc > MAX_FRAMES) ? MAX_FRAMES : fc;
			for (k = 0; k < 115; k++) begin
				pick = $urandom_range(0, 99);
				if (lim == 0 || $urandom_range(0, 5) == 0)
					idx = $urandom_range(0, 32767);
				else
					idx = $urandom_range(0, lim - 1);
				if (pick < 3)
					push_cmd(OP_CLEAR, idx, 1'($urandom));
				else if (pick < 43)
					push_cmd(OP_ALLOC, idx, 1'($urandom));
				else if (pick < 70)
					push_cmd(OP_WRITE, idx, 1'($urandom));
				else
					push_cmd(OP_READ, idx, 1'($urandom));
			end
			drain();
		end

		repeat (600) @(posedge clk);
		if (errors == 0)
			$display("PASS bitmap_page_frame_allocator");
		else
			$display("FAIL bitmap_page_frame_allocator");
		$finish;
	end

	initial begin
		#40000000;
		$display("FAIL bitmap_page_frame_allocator");
		$finish;
	end

endmodule
